### rtl/csrgs_pkg.sv
// ----------------------------------------------------------------------------
// csrgs_pkg
// Shared types, codes and helpers for the CSR Gauss-Seidel solver core.
// ----------------------------------------------------------------------------
package csrgs_pkg;

    // Item function codes carried on the input tuser
    typedef enum logic [2:0] {
        FUNC_ROW_PTR = 3'd0,
        FUNC_NONZERO = 3'd1,
        FUNC_RHS     = 3'd2,
        FUNC_GUESS   = 3'd3,
        FUNC_SOLVE   = 3'd4,
        FUNC_READ    = 3'd5,
        FUNC_RSVD6   = 3'd6,
        FUNC_RSVD7   = 3'd7
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_DIAG = 2'd1,
        STAT_SAT  = 2'd2,
        STAT_RSVD = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic CFG_SWEEPS = 1'b0;
    localparam logic CFG_ROWS   = 1'b1;

    localparam logic [9:0] SWEEPS_RESET = 10'd100;
    localparam logic [8:0] ROWS_RESET   = 9'd1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_OUT,
        ST_SWEEP_CHECK,
        ST_ROW_CHECK,
        ST_PTR0,
        ST_PTR1,
        ST_NZ_CHECK,
        ST_NZ_EVAL,
        ST_MUL,
        ST_ACC,
        ST_DIAG_CHECK,
        ST_NUM,
        ST_DIV_WAIT,
        ST_DONE_OUT
    } state_t;

    // Divider handshake
    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

    typedef struct packed {
        logic [63:0] value;
        logic        ovf;
    } sat64_t;

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    // Signed 64-bit add with saturation
    function automatic sat64_t sat_add64(input logic [63:0] a, input logic [63:0] b);
        sat64_t      r;
        logic [63:0] s;
        s = a + b;
        r.ovf = (a[63] == b[63]) && (s[63] != a[63]);
        r.value = r.ovf ? (a[63] ? S64_MIN : S64_MAX) : s;
        return r;
    endfunction

    // Signed 64-bit negate with saturation
    function automatic sat64_t sat_neg64(input logic [63:0] a);
        sat64_t r;
        r.ovf = (a == S64_MIN);
        r.value = r.ovf ? S64_MAX : (64'd0 - a);
        return r;
    endfunction

endpackage

### rtl/csrgs_div.sv
// ----------------------------------------------------------------------------
// csrgs_div
// Restoring divider, one quotient bit per cycle: 64-bit signed numerator by
// 32-bit signed denominator, returns quotient magnitude and sign.
// ----------------------------------------------------------------------------
module csrgs_div (
    input  logic                clk,
    input  logic                rst_n,
    input  csrgs_pkg::div_ctl_t ctl_in,
    output csrgs_pkg::div_ctl_t ctl_out,
    input  logic [63:0]         num,
    input  logic [31:0]         den,
    output logic [63:0]         quo_mag,
    output logic                quo_neg
);
    import csrgs_pkg::*;

    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [63:0] dvd_reg;
    logic [31:0] dm_reg;
    logic        neg_reg;
    logic        done_reg;

    logic [32:0] rem_sh;
    logic        ge;

    // One restoring step
    assign rem_sh = {rem_reg, dvd_reg[63]};
    assign ge     = rem_sh >= {1'b0, dm_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl_in.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: operand magnitudes on start, then shift/subtract
    always_ff @(posedge clk)
    begin
        if (ctl_in.start)
        begin
            rem_reg <= 32'd0;
            dvd_reg <= num[63] ? (64'd0 - num) : num;
            dm_reg  <= den[31] ? (32'd0 - den) : den;
            neg_reg <= num[63] ^ den[31];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 32'(rem_sh - {1'b0, dm_reg}) : rem_sh[31:0];
            dvd_reg <= {dvd_reg[62:0], ge};
        end
    end

    assign ctl_out.start = 1'b0;
    assign ctl_out.done  = done_reg;
    assign quo_mag       = dvd_reg;
    assign quo_neg       = neg_reg;

endmodule

### rtl/csr_gauss_seidel_solver_core.sv
// Load items are written while idle; a read item's solution word is registered at
// its beat and its answer in ST_READ_OUT. A solve per sweep passes ST_SWEEP_CHECK,
// per row ST_ROW_CHECK, ST_PTR0, ST_PTR1, per nonzero ST_NZ_CHECK, ST_NZ_EVAL (and
// ST_MUL, ST_ACC), then ST_DIAG_CHECK, ST_NUM, ST_DIV_WAIT (serial divider); one item.
// Throughput: one item at a time; the single shared multiplier, accumulator
// and divider under the sequencer set the solve time.
// Reset clears control, config (100 sweeps, 1 row) and flags; stores are not cleared.
// ----------------------------------------------------------------------------
// csr_gauss_seidel_solver_core
// Forward Gauss-Seidel sweeps on a CSR matrix in Q16.16, sequenced over one
// multiplier, one saturating accumulator and one serial divider.
// ----------------------------------------------------------------------------
module csr_gauss_seidel_solver_core #(
    parameter int MAX_ROWS     = 256,
    parameter int MAX_NONZEROS = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // slot[10:0], column[18:11], pointer_value[30:19],
                                   // value[62:31], zero[63]
    input  logic [2:0]  s_tuser,   // func[2:0]
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_value[31:0], status[33:32], zero[39:34]
    output logic        m_tuser,   // solve_done[0]
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data
);
    import csrgs_pkg::*;

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RSW = $clog2(MAX_ROWS + 1);
    localparam int NZW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;

    // Input fields
    func_t              in_func;
    logic [10:0]        in_slot;
    logic [7:0]         in_column;
    logic [11:0]        in_ptr;
    logic signed [31:0] in_value;
    logic               in_acc;

    assign in_func   = func_t'(s_tuser);
    assign in_slot   = s_tdata[10:0];
    assign in_column = s_tdata[18:11];
    assign in_ptr    = s_tdata[30:19];
    assign in_value  = s_tdata[62:31];
    assign in_acc    = s_tvalid && s_tready;

    // Memories
    logic [11:0] rs_mem  [MAX_ROWS+1];
    logic [7:0]  col_mem [MAX_NONZEROS];
    logic [31:0] val_mem [MAX_NONZEROS];
    logic [31:0] rhs_mem [MAX_ROWS];
    logic [31:0] sol_mem [MAX_ROWS];

    logic [11:0] rs_rd_reg;
    logic [7:0]  col_rd_reg;
    logic [31:0] val_rd_reg;
    logic [31:0] rhs_rd_reg;
    logic [31:0] sol_rd_reg;

    // Control and datapath registers
    state_t      state_reg, state_next;
    logic [9:0]  sweeps_cfg_reg;
    logic [8:0]  rows_cfg_reg;
    logic [9:0]  sweep_reg;
    logic [RSW-1:0] row_reg;
    logic [12:0] k_reg;
    logic [12:0] end_reg;
    logic [63:0] sigma_reg;
    logic [31:0] diag_reg;
    logic [31:0] a_reg;
    logic [63:0] prod_reg;
    logic [1:0]  flags_reg;
    logic        rd_inrange_reg;
    logic        out_valid_reg;
    logic [31:0] out_value_reg;
    logic [1:0]  out_status_reg;
    logic        out_done_reg;

    // Combinational control
    logic           rs_we, nz_we, rhs_we, sol_we;
    logic [RSW-1:0] rs_waddr, rs_raddr;
    logic [NZW-1:0] nz_waddr, nz_raddr;
    logic [RW-1:0]  rhs_waddr, rhs_raddr;
    logic [RW-1:0]  sol_waddr, sol_raddr;
    logic [31:0]    sol_wdata;
    logic           out_free;
    logic           rows_done, sweeps_done, nz_more;
    logic           col_is_diag, col_in_range;
    int unsigned    rows_lim;

    div_ctl_t    div_in, div_out;
    logic [63:0] quo_mag;
    logic        quo_neg;
    logic [31:0] quo_sat;
    logic        quo_ovf;
    sat64_t      neg_sig, num_sum, acc_sum;
    status_t     cur_status;

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) &&
                       (out_free || !(in_func == FUNC_SOLVE || in_func == FUNC_READ));
    assign cfg_ready = 1'b1;

    assign rows_lim    = (int'(rows_cfg_reg) > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg_reg);
    assign rows_done   = int'(row_reg) >= rows_lim;
    assign sweeps_done = sweep_reg >= sweeps_cfg_reg;
    assign nz_more     = k_reg < end_reg;
    assign col_is_diag = int'(col_rd_reg) == int'(row_reg);
    assign col_in_range = int'(col_rd_reg) < MAX_ROWS;

    // Saturating arithmetic for accumulate and numerator
    assign acc_sum = sat_add64(sigma_reg, prod_reg);
    assign neg_sig = sat_neg64(sigma_reg);
    assign num_sum = sat_add64({{16{rhs_rd_reg[31]}}, rhs_rd_reg, 16'd0}, neg_sig.value);

    // Quotient saturation to Q16.16
    always_comb
    begin
        if (quo_neg)
        begin
            quo_ovf = quo_mag > 64'h0000_0000_8000_0000;
            quo_sat = quo_ovf ? 32'h8000_0000 : 32'(64'd0 - quo_mag);
        end
        else
        begin
            quo_ovf = quo_mag > 64'h0000_0000_7FFF_FFFF;
            quo_sat = quo_ovf ? 32'h7FFF_FFFF : quo_mag[31:0];
        end
    end

    assign cur_status = flags_reg[0] ? STAT_DIAG : (flags_reg[1] ? STAT_SAT : STAT_OK);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_func == FUNC_SOLVE)
                    state_next = ST_SWEEP_CHECK;
                else if (in_acc && in_func == FUNC_READ)
                    state_next = ST_READ_OUT;
            end
            ST_READ_OUT:    state_next = ST_IDLE;
            ST_SWEEP_CHECK: state_next = sweeps_done ? ST_DONE_OUT : ST_ROW_CHECK;
            ST_ROW_CHECK:   state_next = rows_done ? ST_SWEEP_CHECK : ST_PTR0;
            ST_PTR0:        state_next = ST_PTR1;
            ST_PTR1:        state_next = ST_NZ_CHECK;
            ST_NZ_CHECK:    state_next = nz_more ? ST_NZ_EVAL : ST_DIAG_CHECK;
            ST_NZ_EVAL:
                state_next = (!col_is_diag && col_in_range) ? ST_MUL : ST_NZ_CHECK;
            ST_MUL:         state_next = ST_ACC;
            ST_ACC:         state_next = ST_NZ_CHECK;
            ST_DIAG_CHECK:  state_next = (diag_reg == 32'd0) ? ST_ROW_CHECK : ST_NUM;
            ST_NUM:         state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:    state_next = div_out.done ? ST_ROW_CHECK : ST_DIV_WAIT;
            ST_DONE_OUT:    state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // Memory controls
    always_comb
    begin
        rs_we     = 1'b0;
        nz_we     = 1'b0;
        rhs_we    = 1'b0;
        sol_we    = 1'b0;
        rs_waddr  = RSW'(in_slot);
        nz_waddr  = NZW'(in_slot);
        rhs_waddr = RW'(in_slot);
        sol_waddr = RW'(in_slot);
        sol_wdata = in_value;
        rs_raddr  = row_reg;
        nz_raddr  = NZW'(k_reg);
        rhs_raddr = RW'(row_reg);
        sol_raddr = RW'(col_rd_reg);
        div_in.start = 1'b0;
        div_in.done  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sol_raddr = RW'(in_slot);
                if (in_acc)
                begin
                    unique case (in_func)
                        FUNC_ROW_PTR: rs_we  = int'(in_slot) <= MAX_ROWS;
                        FUNC_NONZERO: nz_we  = int'(in_slot) < MAX_NONZEROS;
                        FUNC_RHS:     rhs_we = int'(in_slot) < MAX_ROWS;
                        FUNC_GUESS:   sol_we = int'(in_slot) < MAX_ROWS;
                        default:      ;
                    endcase
                end
            end
            ST_PTR0:     rs_raddr = RSW'(int'(row_reg) + 1);
            ST_NUM:      div_in.start = 1'b1;
            ST_DIV_WAIT:
            begin
                sol_waddr = RW'(row_reg);
                sol_wdata = quo_sat;
                sol_we    = div_out.done;
            end
            default:     ;
        endcase
    end

    // Memory arrays, registered reads
    always_ff @(posedge clk)
    begin
        if (rs_we)
            rs_mem[rs_waddr] <= in_ptr;
        if (nz_we)
        begin
            col_mem[nz_waddr] <= in_column;
            val_mem[nz_waddr] <= in_value;
        end
        if (rhs_we)
            rhs_mem[rhs_waddr] <= in_value;
        if (sol_we)
            sol_mem[sol_waddr] <= sol_wdata;
        rs_rd_reg  <= rs_mem[rs_raddr];
        col_rd_reg <= col_mem[nz_raddr];
        val_rd_reg <= val_mem[nz_raddr];
        rhs_rd_reg <= rhs_mem[rhs_raddr];
        sol_rd_reg <= sol_mem[sol_raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sweeps_cfg_reg <= SWEEPS_RESET;
            rows_cfg_reg   <= ROWS_RESET;
            flags_reg      <= 2'b00;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SWEEPS)
                    sweeps_cfg_reg <= cfg_data;
                else
                    rows_cfg_reg <= cfg_data[8:0];
            end
            // error flags
            if (state_reg == ST_IDLE && in_acc && in_func == FUNC_SOLVE)
                flags_reg <= 2'b00;
            else if (state_reg == ST_ACC && acc_sum.ovf)
                flags_reg[1] <= 1'b1;
            else if (state_reg == ST_DIAG_CHECK && diag_reg == 32'd0)
                flags_reg[0] <= 1'b1;
            else if (state_reg == ST_NUM && (num_sum.ovf || neg_sig.ovf))
                flags_reg[1] <= 1'b1;
            else if (state_reg == ST_DIV_WAIT && div_out.done && quo_ovf)
                flags_reg[1] <= 1'b1;
            // output beat
            if (state_reg == ST_READ_OUT || state_reg == ST_DONE_OUT)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                sweep_reg      <= 10'd0;
                rd_inrange_reg <= int'(in_slot) < MAX_ROWS;
            end
            ST_READ_OUT:
            begin
                out_value_reg  <= rd_inrange_reg ? sol_rd_reg : 32'd0;
                out_status_reg <= cur_status;
                out_done_reg   <= 1'b0;
            end
            ST_SWEEP_CHECK:
            begin
                row_reg <= '0;
            end
            ST_ROW_CHECK:
            begin
                if (rows_done)
                    sweep_reg <= sweep_reg + 10'd1;
            end
            ST_PTR0:
            begin
                k_reg <= {1'b0, rs_rd_reg};
            end
            ST_PTR1:
            begin
                end_reg   <= (int'(rs_rd_reg) > MAX_NONZEROS) ? 13'(MAX_NONZEROS)
                                                               : {1'b0, rs_rd_reg};
                sigma_reg <= 64'd0;
                diag_reg  <= 32'd0;
            end
            ST_NZ_EVAL:
            begin
                a_reg <= val_rd_reg;
                if (col_is_diag)
                    diag_reg <= val_rd_reg;
                if (col_is_diag || !col_in_range)
                    k_reg <= k_reg + 13'd1;
            end
            ST_MUL:
            begin
                prod_reg <= 64'($signed(a_reg) * $signed(sol_rd_reg));
            end
            ST_ACC:
            begin
                sigma_reg <= acc_sum.value;
                k_reg     <= k_reg + 13'd1;
            end
            ST_DIAG_CHECK:
            begin
                if (diag_reg == 32'd0)
                    row_reg <= RSW'(int'(row_reg) + 1);
            end
            ST_DIV_WAIT:
            begin
                if (div_out.done)
                    row_reg <= RSW'(int'(row_reg) + 1);
            end
            ST_DONE_OUT:
            begin
                out_value_reg  <= 32'd0;
                out_status_reg <= cur_status;
                out_done_reg   <= 1'b1;
            end
            default: ;
        endcase
    end

    // Shared serial divider; operands are presented in ST_NUM
    csrgs_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (div_in),
        .ctl_out (div_out),
        .num     (num_sum.value),
        .den     (diag_reg),
        .quo_mag (quo_mag),
        .quo_neg (quo_neg)
    );

    // Output port
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_status_reg, out_value_reg};
    assign m_tuser  = out_done_reg;

    // Assertions
    a_solve_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[31:0] == 32'd0))
        else $error("solve result carries nonzero value");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[33:32] != STAT_RSVD))
        else $error("reserved status code on output");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == ST_IDLE))
        else $error("input ready outside idle");

    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_out.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside wait state");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output beat dropped while stalled");

endmodule

### sim/csr_gauss_seidel_solver_checker.sv
// ----------------------------------------------------------------------------
// csr_gauss_seidel_solver_checker
// Watches the input, result and configuration channels of the solver core,
// keeps its own copy of the stores and registers, works out each answer in
// Q16.16 and compares every result beat with the oldest pending answer.
// ----------------------------------------------------------------------------
module csr_gauss_seidel_solver_checker
    import csrgs_pkg::*;
#(
    parameter int MAX_ROWS     = 256,
    parameter int MAX_NONZEROS = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data,
    output int          fail_count,
    output int          open_count,
    output int          checked_count
);

    typedef struct packed {
        logic [31:0] value;
        status_t     status;
        logic        done;
    } answer_t;

    localparam longint Q64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint Q64_MIN = 64'sh8000_0000_0000_0000;

    // Shadow stores and registers
    logic [11:0]        row_ptr [MAX_ROWS+1];
    logic [7:0]         nz_col  [MAX_NONZEROS];
    logic signed [31:0] nz_val  [MAX_NONZEROS];
    logic signed [31:0] rhs_mem [MAX_ROWS];
    logic signed [31:0] x_mem   [MAX_ROWS];
    logic [1:0]         err_flags;
    logic [9:0]         sweeps;
    logic [8:0]         rows;
    answer_t            answers [$];
    int                 fails;
    int                 checked;

    // 64-bit add, clamped to the signed range
    function automatic longint add_clamped(input longint a, input longint b);
        logic [64:0] wide;
        wide = {a[63], a} + {b[63], b};
        if (wide[64] != wide[63])
        begin
            err_flags[1] = 1'b1;
            return wide[64] ? Q64_MIN : Q64_MAX;
        end
        return longint'(wide[63:0]);
    endfunction

    function automatic longint negate_clamped(input longint a);
        if (a == Q64_MIN)
        begin
            err_flags[1] = 1'b1;
            return Q64_MAX;
        end
        return -a;
    endfunction

    // Q32.32 by Q16.16, truncated toward zero, clamped to 32 bits
    function automatic logic [31:0] divide_to_q16(input longint num, input int den);
        bit          negative;
        logic [63:0] mag;
        logic [63:0] dmag;
        logic [63:0] quo;
        negative = (num < 0) != (den < 0);
        mag = (num < 0) ? -num : num;
        dmag = (den < 0) ? -longint'(den) : longint'(den);
        quo = mag / dmag;
        if (negative)
        begin
            if (quo > 64'h8000_0000)
            begin
                err_flags[1] = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(64'd0 - quo);
        end
        if (quo > 64'h7FFF_FFFF)
        begin
            err_flags[1] = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return quo[31:0];
    endfunction

    // One Gauss-Seidel row update with the newest solution values
    function automatic void relax_row(input int j);
        int unsigned first;
        int unsigned last;
        longint      sigma;
        int          diag;
        longint      numer;
        first = row_ptr[j];
        last = row_ptr[j+1];
        if (last > MAX_NONZEROS)
            last = MAX_NONZEROS;
        sigma = 0;
        diag = 0;
        for (int unsigned k = first; k < last; k++)
        begin
            if (nz_col[k] == j)
                diag = nz_val[k];
            else if (nz_col[k] < MAX_ROWS)
                sigma = add_clamped(sigma, longint'(nz_val[k]) * longint'(x_mem[nz_col[k]]));
        end
        if (diag == 0)
        begin
            err_flags[0] = 1'b1;
            return;
        end
        numer = add_clamped(longint'(rhs_mem[j]) <<< 16, negate_clamped(sigma));
        x_mem[j] = divide_to_q16(numer, diag);
    endfunction

    function automatic void sweep_system();
        int nrows;
        nrows = (rows > MAX_ROWS) ? MAX_ROWS : rows;
        err_flags = 2'b00;
        for (int s = 0; s < sweeps; s++)
            for (int j = 0; j < nrows; j++)
                relax_row(j);
    endfunction

    function automatic status_t status_now();
        if (err_flags[0])
            return STAT_DIAG;
        if (err_flags[1])
            return STAT_SAT;
        return STAT_OK;
    endfunction

    // Beat monitor: compare results, track config, predict answers
    always @(posedge clk or negedge rst_n)
    begin : monitor
        answer_t     want;
        func_t       func;
        int unsigned slot;
        if (!rst_n)
        begin
            err_flags = 2'b00;
            sweeps = SWEEPS_RESET;
            rows = ROWS_RESET;
            answers.delete();
            fails = 0;
            checked = 0;
        end
        else
        begin
            // result beat
            if (m_tvalid && m_tready)
            begin
                if (answers.size() == 0)
                begin
                    $error("result beat with no answer pending");
                    fails++;
                end
                else
                begin
                    want = answers.pop_front();
                    checked++;
                    if (m_tdata[31:0] !== want.value)
                    begin
                        $error("result_value: expected %h, got %h", want.value, m_tdata[31:0]);
                        fails++;
                    end
                    if (m_tdata[33:32] !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[33:32]);
                        fails++;
                    end
                    if (m_tuser !== want.done)
                    begin
                        $error("solve_done: expected %0d, got %0d", want.done, m_tuser);
                        fails++;
                    end
                end
            end
            // register write
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SWEEPS)
                    sweeps = cfg_data;
                else
                    rows = cfg_data[8:0];
            end
            // input beat
            if (s_tvalid && s_tready)
            begin
                func = func_t'(s_tuser);
                slot = s_tdata[10:0];
                case (func)
                    FUNC_ROW_PTR:
                        if (slot <= MAX_ROWS)
                            row_ptr[slot] = s_tdata[30:19];
                    FUNC_NONZERO:
                        if (slot < MAX_NONZEROS)
                        begin
                            nz_col[slot] = s_tdata[18:11];
                            nz_val[slot] = s_tdata[62:31];
                        end
                    FUNC_RHS:
                        if (slot < MAX_ROWS)
                            rhs_mem[slot] = s_tdata[62:31];
                    FUNC_GUESS:
                        if (slot < MAX_ROWS)
                            x_mem[slot] = s_tdata[62:31];
                    FUNC_SOLVE:
                    begin
                        sweep_system();
                        answers.push_back('{32'd0, status_now(), 1'b1});
                    end
                    FUNC_READ:
                        answers.push_back('{(slot < MAX_ROWS) ? x_mem[slot] : 32'd0,
                                            status_now(), 1'b0});
                    default:
                    begin
                    end
                endcase
            end
        end
        fail_count <= fails;
        open_count <= answers.size();
        checked_count <= checked;
    end

endmodule

### sim/csr_gauss_seidel_solver_core_tb.sv
// ----------------------------------------------------------------------------
// csr_gauss_seidel_solver_core_tb
// Drives load, solve and read beats into the solver core: a directed set of
// corner cases, random small CSR systems with noise beats, a full-row-count
// system and a long sweep run, under random idling and a long result stall.
// ----------------------------------------------------------------------------
module csr_gauss_seidel_solver_core_tb;
    import csrgs_pkg::*;

    localparam int MAX_ROWS     = 256;
    localparam int MAX_NONZEROS = 2048;
    localparam int QUIET_LIMIT  = 300000;
    localparam int FILLED_ROWS  = 16;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // slot[10:0], column[18:11], pointer_value[30:19],
                            // value[62:31], zero[63]
    logic [2:0]  s_tuser;   // func[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // result_value[31:0], status[33:32], zero[39:34]
    logic        m_tuser;   // solve_done[0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [9:0]  cfg_data;

    int fail_count;
    int open_count;
    int checked_count;

    // Stimulus-side record of what has been loaded
    bit          ptr_ok   [MAX_ROWS+1];
    int          ptr_val  [MAX_ROWS+1];
    bit          nz_ok    [MAX_NONZEROS];
    int          nz_col   [MAX_NONZEROS];
    bit          rhs_ok   [MAX_ROWS];
    bit          guess_ok [MAX_ROWS];
    int          loaded_x [$];

    int send_pct;
    int recv_pct;
    bit stall_burst;
    int beats_sent;
    int solves_sent;
    int reg_writes;
    int quiet;

    csr_gauss_seidel_solver_core #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_NONZEROS (MAX_NONZEROS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    csr_gauss_seidel_solver_checker #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_NONZEROS (MAX_NONZEROS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .open_count    (open_count),
        .checked_count (checked_count)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: cycles with no beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result receiver with random stalls and one long hold-off
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_burst)
            begin
                stall_burst = 1'b0;
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= recv_pct);
        end
    end

    // One input beat; returns right after the accepting edge
    task automatic put_item(input func_t f, input int slot, input int column,
                            input int ptr, input logic [31:0] value);
        bit counted;
        bit ready_seen;
        while (send_pct != 0 && $urandom_range(99) < send_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= f;
        s_tdata <= {1'b0, value, ptr[11:0], column[7:0], slot[10:0]};
        // ready is sampled ahead of the edge it qualifies
        do
        begin
            @(negedge clk);
            ready_seen = s_tready;
            @(posedge clk);
        end
        while (!ready_seen);
        counted = 1'b1;
        case (f)
            FUNC_ROW_PTR:
                if (slot <= MAX_ROWS)
                begin
                    ptr_ok[slot] = 1'b1;
                    ptr_val[slot] = ptr;
                end
                else
                    counted = 1'b0;
            FUNC_NONZERO:
            begin
                nz_ok[slot] = 1'b1;
                nz_col[slot] = column;
            end
            FUNC_RHS:
                if (slot < MAX_ROWS)
                    rhs_ok[slot] = 1'b1;
                else
                    counted = 1'b0;
            FUNC_GUESS:
                if (slot < MAX_ROWS)
                begin
                    if (!guess_ok[slot])
                        loaded_x.push_back(slot);
                    guess_ok[slot] = 1'b1;
                end
                else
                    counted = 1'b0;
            FUNC_SOLVE:
                solves_sent++;
            FUNC_READ:
            begin
            end
            default:
                counted = 1'b0;
        endcase
        if (counted)
            beats_sent++;
    endtask

    // Wait until every answer has come back and the core is idle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (open_count != 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_reg(input logic idx, input int data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data[9:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    function automatic logic [31:0] small_q16(input int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // Load whatever the coming solve would read that was never written
    task automatic fill_gaps(input int nrows);
        int last;
        for (int j = 0; j <= nrows; j++)
            if (!ptr_ok[j])
                put_item(FUNC_ROW_PTR, j, 0, 0, 0);
        for (int j = 0; j < nrows; j++)
        begin
            last = (ptr_val[j+1] > MAX_NONZEROS) ? MAX_NONZEROS : ptr_val[j+1];
            for (int k = ptr_val[j]; k < last; k++)
                if (!nz_ok[k])
                    put_item(FUNC_NONZERO, k, $urandom_range(0, 255), 0, small_q16(32'h10000));
            for (int k = ptr_val[j]; k < last; k++)
                if (nz_col[k] != j && !guess_ok[nz_col[k]])
                    put_item(FUNC_GUESS, nz_col[k], 0, 0, small_q16(32'h40000));
            // an empty row never reads its right-hand side
            if (!rhs_ok[j] && ptr_val[j] < last)
                put_item(FUNC_RHS, j, 0, 0, small_q16(32'h80000));
        end
    endtask

    task automatic run_solve(input int rows_cfg, input int sweeps_cfg);
        int nrows;
        nrows = rows_cfg & 32'h1FF;
        if (nrows > MAX_ROWS)
            nrows = MAX_ROWS;
        fill_gaps(nrows);
        drain();
        set_reg(CFG_ROWS, rows_cfg);
        set_reg(CFG_SWEEPS, sweeps_cfg);
        put_item(FUNC_SOLVE, $urandom_range(0, 2047), $urandom_range(0, 255),
                 $urandom_range(0, 4095), $urandom());
    endtask

    task automatic read_back(input int count);
        for (int i = 0; i < count; i++)
            if (loaded_x.size() == 0 || $urandom_range(5) == 0)
                put_item(FUNC_READ, $urandom_range(MAX_ROWS, 2047), 0, 0, 0);
            else
                put_item(FUNC_READ, loaded_x[$urandom_range(0, loaded_x.size() - 1)],
                         $urandom_range(0, 255), $urandom_range(0, 4095), $urandom());
    endtask

    // Beat that the core ignores
    task automatic noise_item();
        case ($urandom_range(3))
            0: put_item(FUNC_ROW_PTR, $urandom_range(MAX_ROWS + 1, 2047), 0,
                        $urandom_range(0, 4095), $urandom());
            1: put_item(FUNC_RHS, $urandom_range(MAX_ROWS, 2047), 0, 0, $urandom());
            2: put_item(FUNC_GUESS, $urandom_range(MAX_ROWS, 2047), 0, 0, $urandom());
            default: put_item($urandom_range(0, 1) ? FUNC_RSVD6 : FUNC_RSVD7,
                              $urandom_range(0, 2047), $urandom_range(0, 255),
                              $urandom_range(0, 4095), $urandom());
        endcase
    endtask

    // A small random CSR system, then solve and read back
    task automatic random_system();
        int          nrows;
        int          flavor;
        int          victim;
        int          base;
        int          total;
        int          pos;
        int          dpos;
        int          col;
        int          row_nnz [5];
        logic [31:0] diag_val;
        logic [31:0] val;
        nrows = $urandom_range(1, 4);
        flavor = $urandom_range(0, 9);
        victim = $urandom_range(0, nrows - 1);
        total = 0;
        for (int j = 0; j < nrows; j++)
        begin
            row_nnz[j] = $urandom_range(1, 4);
            total += row_nnz[j];
        end
        base = (flavor == 9) ? MAX_NONZEROS - total : $urandom_range(0, MAX_NONZEROS - 1 - total);
        // row pointers; last one past the store end for the clamp case
        pos = base;
        for (int j = 0; j <= nrows; j++)
        begin
            put_item(FUNC_ROW_PTR, j, $urandom_range(0, 255),
                     (j == nrows && flavor == 9) ? $urandom_range(2048, 4095) : pos,
                     $urandom());
            if (j < nrows)
                pos += row_nnz[j];
            if ($urandom_range(7) == 0)
                noise_item();
        end
        // start past end: row 1 empty, row 0 runs long
        if (flavor == 8 && nrows >= 2)
            put_item(FUNC_ROW_PTR, 1, 0, base + total + 3, 0);
        // nonzeros
        pos = base;
        for (int j = 0; j < nrows; j++)
        begin
            dpos = $urandom_range(0, row_nnz[j] - 1);
            if (flavor == 1 && j == victim)
                dpos = -1;
            diag_val = $urandom_range(32'h20000, 32'h80000);
            if ($urandom_range(1))
                diag_val = -diag_val;
            if (flavor == 0 && j == victim)
                diag_val = 0;
            if (flavor == 3)
                diag_val = $urandom_range(1, 255);
            for (int e = 0; e < row_nnz[j]; e++)
            begin
                col = (j + 1 + $urandom_range(0, 254)) % 256;
                val = (flavor == 3) ? $urandom() : small_q16(32'h10000);
                if (e == dpos)
                begin
                    col = j;
                    val = diag_val;
                end
                else if (flavor == 2 && e == row_nnz[j] - 1)
                    col = j;
                put_item(FUNC_NONZERO, pos + e, col, $urandom_range(0, 4095), val);
            end
            pos += row_nnz[j];
        end
        for (int j = 0; j < nrows; j++)
        begin
            put_item(FUNC_RHS, j, 0, 0, (flavor == 3) ? $urandom() : small_q16(32'h100000));
            put_item(FUNC_GUESS, j, 0, 0, (flavor == 3) ? $urandom() : small_q16(32'h40000));
        end
        if ($urandom_range(3) == 0)
            read_back(1);
        run_solve(nrows | ($urandom_range(0, 3) == 0 ? 512 : 0), $urandom_range(1, 4));
        read_back($urandom_range(1, 3));
    endtask

    // Stimulus
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        stall_burst = 1'b0;
        send_pct = 0;
        recv_pct = 0;
        beats_sent = 0;
        solves_sent = 0;
        reg_writes = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: out-of-range read at reset, extreme values, ignored beats
        put_item(FUNC_READ, 2047, 0, 0, 0);
        put_item(FUNC_ROW_PTR, 0, 0, 0, 0);
        put_item(FUNC_ROW_PTR, 1, 0, 2, 0);
        put_item(FUNC_NONZERO, 0, 0, 0, 32'h8000_0000);
        put_item(FUNC_NONZERO, 1, 255, 4095, 32'h7FFF_FFFF);
        put_item(FUNC_RHS, 0, 0, 0, 32'h7FFF_FFFF);
        put_item(FUNC_GUESS, 255, 0, 0, 32'h8000_0000);
        put_item(FUNC_GUESS, 0, 0, 0, 32'h0001_0000);
        put_item(FUNC_ROW_PTR, 2047, 255, 4095, 32'hFFFF_FFFF);
        put_item(FUNC_RHS, 2047, 255, 4095, 32'hFFFF_FFFF);
        put_item(FUNC_GUESS, MAX_ROWS, 0, 0, 32'hFFFF_FFFF);
        put_item(FUNC_RSVD6, 2047, 255, 4095, 32'hFFFF_FFFF);
        put_item(FUNC_RSVD7, 2047, 255, 4095, 32'hFFFF_FFFF);
        // zero sweeps still answers
        run_solve(1, 0);
        read_back(1);
        run_solve(1, 1);
        put_item(FUNC_READ, 0, 0, 0, 0);
        put_item(FUNC_READ, 255, 0, 0, 0);
        // zero rows: empty solve
        run_solve(0, 1);
        // zero diagonal
        put_item(FUNC_NONZERO, 0, 0, 0, 0);
        run_solve(1, 2);
        put_item(FUNC_READ, 0, 0, 0, 0);

        // Random systems under three idling mixes
        while (beats_sent < 220)
        begin
            if (beats_sent < 85)
            begin
                send_pct = 35;
                recv_pct = 64;
            end
            else if (beats_sent < 150)
            begin
                send_pct = 64;
                recv_pct = 35;
            end
            else
            begin
                send_pct = 0;
                recv_pct = 0;
            end
            random_system();
            if (solves_sent == 6)
            begin
                // long result hold-off while reads keep coming
                stall_burst = 1'b1;
                read_back(8);
            end
        end

        // Row count above the limit: first rows diagonal, the rest empty
        for (int j = 0; j <= MAX_ROWS; j++)
            put_item(FUNC_ROW_PTR, j, 0, (j < FILLED_ROWS) ? j : FILLED_ROWS, 0);
        for (int j = 0; j < FILLED_ROWS; j++)
        begin
            put_item(FUNC_NONZERO, j, j, 0, 32'h0004_0000 + $urandom_range(0, 32'h3FFFF));
            put_item(FUNC_RHS, j, 0, 0, $urandom());
        end
        run_solve(300, 1);
        read_back(4);
        // Most sweeps on one row
        put_item(FUNC_GUESS, 0, 0, 0, small_q16(32'h10000));
        run_solve(1, 1000);
        read_back(2);

        drain();
        $display("Sent %0d beats with %0d solves and %0d register writes;",
                 beats_sent, solves_sent, reg_writes);
        $display("compared %0d results across idling mixes and a long result stall.",
                 checked_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### csr_gauss_seidel_solver_core.f
rtl/csrgs_pkg.sv
rtl/csrgs_div.sv
rtl/csr_gauss_seidel_solver_core.sv
sim/csr_gauss_seidel_solver_checker.sv
sim/csr_gauss_seidel_solver_core_tb.sv
